### rtl/clsf_pkg.sv
`default_nettype none
package clsf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int INT_FRAC  = 28;

  localparam int MAG_W = 32;
  localparam int SQ_W  = 66;
  localparam int LEN_W = 33;
  localparam int REM_W = 35;
  localparam int EQ_W  = 32;
  localparam int FM_W  = 61;
  localparam int F2_W  = 122;
  localparam int QT_W  = 63;
  localparam int GM_W  = 63;
  localparam int KG_W  = 95;
  localparam int P_W   = 127;
  localparam int DV_W  = 61;
  localparam int OQ_W  = 33;

  localparam int SQRT_CELLS = LEN_W;
  localparam int LATENCY    = 204;

  localparam logic [1:0] REG_STIFFNESS   = 2'd0;
  localparam logic [1:0] REG_REST_LENGTH = 2'd1;
  localparam logic [1:0] REG_ABS_DEN     = 2'd2;

  localparam logic [31:0] STIFF_RESET = 32'(1 << FRAC_BITS);
  localparam logic [31:0] REST_RESET  = 32'(1 << FRAC_BITS);

  localparam logic [F2_W-1:0] NINE     = F2_W'(9) << (2 * INT_FRAC);
  localparam logic [QT_W-1:0] TERM_CAP = QT_W'(1) << 62;
  localparam logic [31:0]     F_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0]     F_MIN    = 32'h8000_0000;

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic           pv;
    mag_t [2:0]     dm;
    logic [2:0]     dn;
  } sq_side_t;

  typedef struct packed {
    logic             pv;
    logic             zl;
    logic             fneg;
    logic [LEN_W-1:0] len;
    mag_t [2:0]       dm;
    logic [2:0]       dn;
  } fd_side_t;

  typedef struct packed {
    logic             pv;
    logic             zl;
    logic             denz;
    logic             fneg;
    logic             dneg;
    logic             clamp;
    logic [FM_W-1:0]  fm;
    logic [LEN_W-1:0] len;
    mag_t [2:0]       dm;
    logic [2:0]       dn;
  } qd_side_t;

  typedef struct packed {
    logic             pv;
    logic             zl;
    logic             denz;
    logic [LEN_W-1:0] len;
    mag_t [2:0]       dm;
    logic [2:0]       dn;
  } tail_t;

  typedef struct packed {
    logic pv;
    logic zl;
    logic denz;
    logic neg;
    logic dz;
    logic dn;
    logic sat;
  } lane_side_t;

endpackage
`default_nettype wire

### rtl/clsf_sqrt_cell.sv
`default_nettype none
module clsf_sqrt_cell import clsf_pkg::*; #(
  parameter int SW = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             vld,
  input  wire logic [SQ_W-1:0]  rad,
  input  wire logic [LEN_W-1:0] root,
  input  wire logic [REM_W-1:0] rem,
  input  wire logic [SW-1:0]    side,
  output logic                  vld_q,
  output logic [SQ_W-1:0]       rad_q,
  output logic [LEN_W-1:0]      root_q,
  output logic [REM_W-1:0]      rem_q,
  output logic [SW-1:0]         side_q
);

  logic [REM_W+1:0] t, trial, diff;
  logic             ge;
  logic [REM_W-1:0] rem_next;
  logic [LEN_W-1:0] root_next;

  always_comb begin
    t         = {rem, rad[SQ_W-1 -: 2]};
    trial     = {2'b00, root, 2'b01};
    diff      = t - trial;
    ge        = t >= trial;
    rem_next  = ge ? diff[REM_W-1:0] : t[REM_W-1:0];
    root_next = {root[LEN_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld;
    end
    rad_q  <= {rad[SQ_W-3:0], 2'b00};
    root_q <= root_next;
    rem_q  <= rem_next;
    side_q <= side;
  end

endmodule
`default_nettype wire

### rtl/clsf_div_cell.sv
`default_nettype none
module clsf_div_cell #(
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          vld,
  input  wire logic [DW-1:0] rem,
  input  wire logic [QW-1:0] low,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side,
  output logic               vld_q,
  output logic [DW-1:0]      rem_q,
  output logic [QW-1:0]      low_q,
  output logic [DW-1:0]      den_q,
  output logic [SW-1:0]      side_q
);

  logic [DW:0]   t, diff;
  logic          ge;
  logic [DW-1:0] rem_next;

  always_comb begin
    t        = {rem, low[QW-1]};
    diff     = t - {1'b0, den};
    ge       = t >= {1'b0, den};
    rem_next = ge ? diff[DW-1:0] : t[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld;
    end
    rem_q  <= rem_next;
    low_q  <= {low[QW-2:0], ge};
    den_q  <= den;
    side_q <= side;
  end

endmodule
`default_nettype wire

### rtl/clsf_div_chain.sv
`default_nettype none
module clsf_div_chain #(
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          vld,
  input  wire logic [DW-1:0] rem,
  input  wire logic [QW-1:0] low,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side,
  output logic               vld_q,
  output logic [QW-1:0]      quo,
  output logic [SW-1:0]      side_q
);

  logic          cv [0:QW];
  logic [DW-1:0] cr [0:QW];
  logic [QW-1:0] cl [0:QW];
  logic [DW-1:0] cd [0:QW];
  logic [SW-1:0] cs [0:QW];

  assign cv[0] = vld;
  assign cr[0] = rem;
  assign cl[0] = low;
  assign cd[0] = den;
  assign cs[0] = side;

  for (genvar j = 0; j < QW; j++) begin : g_cell
    clsf_div_cell #(.DW(DW), .QW(QW), .SW(SW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .vld    (cv[j]),
      .rem    (cr[j]),
      .low    (cl[j]),
      .den    (cd[j]),
      .side   (cs[j]),
      .vld_q  (cv[j+1]),
      .rem_q  (cr[j+1]),
      .low_q  (cl[j+1]),
      .den_q  (cd[j+1]),
      .side_q (cs[j+1])
    );
  end

  assign vld_q  = cv[QW];
  assign quo    = cl[QW];
  assign side_q = cs[QW];

endmodule
`default_nettype wire

### rtl/chain_link_spring_force.sv
// Pipeline: a word accepted with start passes the edge vector, square root chain, stretch divide,
// denominator, term divide, g and k stages and per-axis force divides; done flags its result.
// Throughput: one word per cycle; busy never rises, set by the bit-per-cell chains
// (square root, stretch divide, term divide, three force divides).
// Reset: clears the pipeline valid bits and loads the register defaults.
`default_nettype none
module chain_link_spring_force import clsf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [31:0] wr_data,
  input  wire logic        first_present,
  input  wire logic        second_present,
  input  wire logic [31:0] first_x,
  input  wire logic [31:0] first_y,
  input  wire logic [31:0] first_z,
  input  wire logic [31:0] second_x,
  input  wire logic [31:0] second_y,
  input  wire logic [31:0] second_z,
  output logic             pair_valid,
  output logic             degenerate,
  output logic [31:0]      force_x,
  output logic [31:0]      force_y,
  output logic [31:0]      force_z
);

  logic [31:0] stiffness, rest_length;
  logic        abs_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness   <= STIFF_RESET;
      rest_length <= REST_RESET;
      abs_den     <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_STIFFNESS:   stiffness   <= wr_data;
        REG_REST_LENGTH: rest_length <= wr_data;
        REG_ABS_DEN:     abs_den     <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // edge vector
  logic [32:0] d [3];
  sq_side_t    s0_next, s0, m1, m2;
  logic        s0_vld, m1_vld, m2_vld;
  logic [63:0] m1_sq [3];
  logic [SQ_W-1:0] m2_sum;

  always_comb begin
    logic [32:0] nd;
    d[0] = {second_x[31], second_x} - {first_x[31], first_x};
    d[1] = {second_y[31], second_y} - {first_y[31], first_y};
    d[2] = {second_z[31], second_z} - {first_z[31], first_z};
    s0_next.pv = first_present & second_present;
    for (int i = 0; i < 3; i++) begin
      nd = 33'd0 - d[i];
      s0_next.dn[i] = d[i][32];
      s0_next.dm[i] = d[i][32] ? nd[31:0] : d[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
    end else begin
      s0_vld <= start & ~busy;
      m1_vld <= s0_vld;
      m2_vld <= m1_vld;
    end
    s0 <= s0_next;
    m1 <= s0;
    for (int i = 0; i < 3; i++) begin
      m1_sq[i] <= s0.dm[i] * s0.dm[i];
    end
    m2     <= m1;
    m2_sum <= SQ_W'(m1_sq[0]) + SQ_W'(m1_sq[1]) + SQ_W'(m1_sq[2]);
  end

  // square root chain
  localparam int SQS_W = $bits(sq_side_t);
  logic             sq_vld  [0:SQRT_CELLS];
  logic [SQ_W-1:0]  sq_rad  [0:SQRT_CELLS];
  logic [LEN_W-1:0] sq_root [0:SQRT_CELLS];
  logic [REM_W-1:0] sq_rem  [0:SQRT_CELLS];
  logic [SQS_W-1:0] sq_side [0:SQRT_CELLS];

  assign sq_vld[0]  = m2_vld;
  assign sq_rad[0]  = m2_sum;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_side[0] = m2;

  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
    clsf_sqrt_cell #(.SW(SQS_W)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .vld    (sq_vld[j]),
      .rad    (sq_rad[j]),
      .root   (sq_root[j]),
      .rem    (sq_rem[j]),
      .side   (sq_side[j]),
      .vld_q  (sq_vld[j+1]),
      .rad_q  (sq_rad[j+1]),
      .root_q (sq_root[j+1]),
      .rem_q  (sq_rem[j+1]),
      .side_q (sq_side[j+1])
    );
  end

  // stretch magnitude
  sq_side_t         sqo;
  logic [LEN_W-1:0] len;
  logic [EQ_W-1:0]  eq;
  logic [LEN_W:0]   diff, ndiff;
  logic [LEN_W-1:0] amag;
  fd_side_t         fd_in, fd_out;
  logic             fd_vld;
  logic [FM_W-1:0]  fd_q;

  always_comb begin
    sqo   = sq_side[SQRT_CELLS];
    len   = sq_root[SQRT_CELLS];
    eq    = (rest_length == '0) ? EQ_W'(1) : rest_length;
    diff  = {1'b0, len} - {2'b00, eq};
    ndiff = '0 - diff;
    amag  = diff[LEN_W] ? ndiff[LEN_W-1:0] : diff[LEN_W-1:0];
    fd_in.pv   = sqo.pv;
    fd_in.zl   = len == '0;
    fd_in.fneg = diff[LEN_W];
    fd_in.len  = len;
    fd_in.dm   = sqo.dm;
    fd_in.dn   = sqo.dn;
  end

  clsf_div_chain #(.DW(EQ_W), .QW(FM_W), .SW($bits(fd_side_t))) u_fdiv (
    .clk    (clk),
    .rst    (rst),
    .vld    (sq_vld[SQRT_CELLS]),
    .rem    ('0),
    .low    ({amag, INT_FRAC'(0)}),
    .den    (eq),
    .side   (fd_in),
    .vld_q  (fd_vld),
    .quo    (fd_q),
    .side_q (fd_out)
  );

  // denominator
  logic             f1_vld, f2_vld, f3_vld;
  fd_side_t         f1, f2, f3;
  logic [FM_W-1:0]  f1_fm, f2_fm, f3_fm;
  logic [63:0]      f1_ll;
  logic [60:0]      f1_lh;
  logic [57:0]      f1_hh;
  logic [F2_W-1:0]  f2_sq, f3_den;
  logic             f3_dneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
      f3_vld <= 1'b0;
    end else begin
      f1_vld <= fd_vld;
      f2_vld <= f1_vld;
      f3_vld <= f2_vld;
    end
    f1    <= fd_out;
    f1_fm <= fd_q;
    f1_ll <= fd_q[31:0] * fd_q[31:0];
    f1_lh <= fd_q[31:0] * fd_q[60:32];
    f1_hh <= fd_q[60:32] * fd_q[60:32];
    f2    <= f1;
    f2_fm <= f1_fm;
    f2_sq <= {f1_hh, 64'd0} + {28'd0, f1_lh, 33'd0} + {58'd0, f1_ll};
    f3    <= f2;
    f3_fm <= f2_fm;
    if (f2_sq < NINE) begin
      f3_den  <= NINE - f2_sq;
      f3_dneg <= 1'b0;
    end else begin
      f3_den  <= f2_sq - NINE;
      f3_dneg <= ~abs_den;
    end
  end

  // f / den term
  qd_side_t        qd_in, qd_out;
  logic [F2_W-1:0] qd_rem;
  logic            qd_vld;
  logic [QT_W-1:0] qd_q;

  always_comb begin
    qd_rem       = {68'd0, f3_fm[FM_W-1:7]};
    qd_in.pv     = f3.pv;
    qd_in.zl     = f3.zl;
    qd_in.denz   = f3_den == '0;
    qd_in.fneg   = f3.fneg;
    qd_in.dneg   = f3_dneg;
    qd_in.clamp  = qd_rem >= f3_den;
    qd_in.fm     = f3_fm;
    qd_in.len    = f3.len;
    qd_in.dm     = f3.dm;
    qd_in.dn     = f3.dn;
  end

  clsf_div_chain #(.DW(F2_W), .QW(QT_W), .SW($bits(qd_side_t))) u_qdiv (
    .clk    (clk),
    .rst    (rst),
    .vld    (f3_vld),
    .rem    (qd_rem),
    .low    ({f3_fm[6:0], 56'd0}),
    .den    (f3_den),
    .side   (qd_in),
    .vld_q  (qd_vld),
    .quo    (qd_q),
    .side_q (qd_out)
  );

  // g = f + term, then k * |g| * |d|
  logic            g1_vld, g2_vld, g3_vld;
  logic            k1_vld, k2_vld, k3_vld, k4_vld;
  tail_t           g1, g2, g3, k1, k2, k3, k4;
  logic [QT_W-1:0] g1_qc;
  logic            g1_qneg, g1_fneg;
  logic [FM_W-1:0] g1_fm;
  logic [64:0]     g2_g, fsg, qsg, g2_ng;
  logic            g3_neg, k1_neg, k2_neg, k3_neg, k4_neg;
  logic [GM_W-1:0] g3_gm;
  logic [63:0]     k1_lo;
  logic [62:0]     k1_hi;
  logic [KG_W-1:0] k2_kg;
  logic [63:0]     k3_p0 [3];
  logic [63:0]     k3_p1 [3];
  logic [62:0]     k3_p2 [3];
  logic [P_W-1:0]  k4_p  [3];
  tail_t           qd_tail;

  always_comb begin
    qd_tail.pv   = qd_out.pv;
    qd_tail.zl   = qd_out.zl;
    qd_tail.denz = qd_out.denz;
    qd_tail.len  = qd_out.len;
    qd_tail.dm   = qd_out.dm;
    qd_tail.dn   = qd_out.dn;
    fsg   = g1_fneg ? 65'd0 - {4'd0, g1_fm} : {4'd0, g1_fm};
    qsg   = g1_qneg ? 65'd0 - {2'd0, g1_qc} : {2'd0, g1_qc};
    g2_ng = 65'd0 - g2_g;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_vld <= 1'b0;
      g2_vld <= 1'b0;
      g3_vld <= 1'b0;
      k1_vld <= 1'b0;
      k2_vld <= 1'b0;
      k3_vld <= 1'b0;
      k4_vld <= 1'b0;
    end else begin
      g1_vld <= qd_vld;
      g2_vld <= g1_vld;
      g3_vld <= g2_vld;
      k1_vld <= g3_vld;
      k2_vld <= k1_vld;
      k3_vld <= k2_vld;
      k4_vld <= k3_vld;
    end
    g1      <= qd_tail;
    g1_qc   <= (qd_out.clamp || qd_q > TERM_CAP) ? TERM_CAP : qd_q;
    g1_qneg <= qd_out.fneg ^ qd_out.dneg;
    g1_fneg <= qd_out.fneg;
    g1_fm   <= qd_out.fm;
    g2      <= g1;
    g2_g    <= fsg + qsg;
    g3      <= g2;
    g3_neg  <= g2_g[64];
    g3_gm   <= g2_g[64] ? g2_ng[GM_W-1:0] : g2_g[GM_W-1:0];
    k1      <= g3;
    k1_neg  <= g3_neg;
    k1_lo   <= stiffness * g3_gm[31:0];
    k1_hi   <= stiffness * g3_gm[62:32];
    k2      <= k1;
    k2_neg  <= k1_neg;
    k2_kg   <= {k1_hi, 32'd0} + {31'd0, k1_lo};
    k3      <= k2;
    k3_neg  <= k2_neg;
    for (int i = 0; i < 3; i++) begin
      k3_p0[i] <= k2_kg[31:0]  * k2.dm[i];
      k3_p1[i] <= k2_kg[63:32] * k2.dm[i];
      k3_p2[i] <= k2_kg[94:64] * k2.dm[i];
    end
    k4     <= k3;
    k4_neg <= k3_neg;
    for (int i = 0; i < 3; i++) begin
      k4_p[i] <= {k3_p2[i], 64'd0} + {31'd0, k3_p1[i], 32'd0} + {63'd0, k3_p0[i]};
    end
  end

  // per-axis divide by L * 2^28 and saturation
  logic [DV_W-1:0] dv;
  logic            lane_vld [3];
  logic [OQ_W-1:0] lane_q   [3];
  lane_side_t      lane_in  [3];
  lane_side_t      lane_out [3];
  logic [31:0]     lane_f   [3];

  assign dv = {k4.len, INT_FRAC'(0)};

  for (genvar i = 0; i < 3; i++) begin : g_lane
    always_comb begin
      lane_in[i].pv   = k4.pv;
      lane_in[i].zl   = k4.zl;
      lane_in[i].denz = k4.denz;
      lane_in[i].neg  = k4_neg ^ k4.dn[i];
      lane_in[i].dz   = k4.dm[i] == '0;
      lane_in[i].dn   = k4.dn[i];
      lane_in[i].sat  = k4_p[i][P_W-1:OQ_W] >= {33'd0, dv};
    end

    clsf_div_chain #(.DW(DV_W), .QW(OQ_W), .SW($bits(lane_side_t))) u_odiv (
      .clk    (clk),
      .rst    (rst),
      .vld    (k4_vld),
      .rem    (k4_p[i][OQ_W+DV_W-1:OQ_W]),
      .low    (k4_p[i][OQ_W-1:0]),
      .den    (dv),
      .side   (lane_in[i]),
      .vld_q  (lane_vld[i]),
      .quo    (lane_q[i]),
      .side_q (lane_out[i])
    );

    always_comb begin
      logic [OQ_W-1:0] nq;
      nq = '0 - lane_q[i];
      if (!lane_out[i].pv || lane_out[i].zl) begin
        lane_f[i] = '0;
      end else if (lane_out[i].denz) begin
        lane_f[i] = lane_out[i].dz ? 32'd0 : (lane_out[i].dn ? F_MIN : F_MAX);
      end else if (lane_out[i].neg) begin
        lane_f[i] = (lane_out[i].sat || lane_q[i] > {1'b0, F_MIN}) ? F_MIN : nq[31:0];
      end else begin
        lane_f[i] = (lane_out[i].sat || lane_q[i] > {1'b0, F_MAX}) ? F_MAX : lane_q[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lane_vld[0] & lane_vld[1] & lane_vld[2];
    end
    pair_valid <= lane_out[0].pv;
    degenerate <= lane_out[0].pv & (lane_out[0].zl | lane_out[0].denz);
    force_x    <= lane_f[0];
    force_y    <= lane_f[1];
    force_z    <= lane_f[2];
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("word lost in pipeline");

  a_absent: assert property (@(posedge clk) disable iff (rst)
    (done && !pair_valid) |-> (!degenerate && force_x == 32'd0 && force_y == 32'd0
                               && force_z == 32'd0))
    else $error("missing bead gave nonzero result");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> pair_valid)
    else $error("degenerate flag without valid pair");

endmodule
`default_nettype wire

### test/clsf_checker.sv
`timescale 1ns / 1ps
module clsf_checker import clsf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        done,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [31:0] wr_data,
  input  wire logic        first_present,
  input  wire logic        second_present,
  input  wire logic [31:0] first_x,
  input  wire logic [31:0] first_y,
  input  wire logic [31:0] first_z,
  input  wire logic [31:0] second_x,
  input  wire logic [31:0] second_y,
  input  wire logic [31:0] second_z,
  input  wire logic        pair_valid,
  input  wire logic        degenerate,
  input  wire logic [31:0] force_x,
  input  wire logic [31:0] force_y,
  input  wire logic [31:0] force_z,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic        pv;
    logic        dg;
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] fz;
  } force_word_t;

  logic [31:0] stiffness;
  logic [31:0] rest_len;
  logic        abs_den;
  force_word_t expected_forces[$];

  assign pending = expected_forces.size();

  function automatic logic [33:0] root_floor(logic [127:0] s);
    logic [33:0]  r;
    logic [33:0]  c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if ({94'd0, c} * {94'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] clamp_q16(logic [127:0] q, logic neg);
    if (neg) begin
      if (q > 128'h8000_0000) return F_MIN;
      return 32'(-q[31:0]);
    end
    if (q > 128'h7FFF_FFFF) return F_MAX;
    return q[31:0];
  endfunction

  function automatic force_word_t link_force(
    logic fp, logic sp, logic [31:0] a [3], logic [31:0] b [3]);
    force_word_t w;
    longint      d [3];
    logic [127:0] dm [3];
    logic [2:0]  dn;
    logic [127:0] s, len, eq, fm, f2, nine, den, num, q, gm, p, dv;
    logic        fneg, dneg, qneg, gneg;
    logic signed [127:0] g;
    w = '0;
    if (!(fp && sp)) return w;
    w.pv = 1'b1;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'($signed(b[i])) - longint'($signed(a[i]));
      dn[i] = d[i] < 0;
      dm[i] = dn[i] ? 128'(-d[i]) : 128'(d[i]);
      s = s + dm[i] * dm[i];
    end
    len = 128'(root_floor(s));
    if (len == 0) begin
      w.dg = 1'b1;
      return w;
    end
    eq = rest_len != 0 ? 128'(rest_len) : 128'd1;
    fneg = len < eq;
    fm = fneg ? eq - len : len - eq;
    fm = (fm << INT_FRAC) / eq;
    f2 = fm * fm;
    nine = 128'd9 << (2 * INT_FRAC);
    dneg = !(f2 < nine);
    den = dneg ? f2 - nine : nine - f2;
    if (abs_den) dneg = 1'b0;
    if (den == 0) begin
      w.dg = 1'b1;
      w.fx = d[0] == 0 ? 32'd0 : (dn[0] ? F_MIN : F_MAX);
      w.fy = d[1] == 0 ? 32'd0 : (dn[1] ? F_MIN : F_MAX);
      w.fz = d[2] == 0 ? 32'd0 : (dn[2] ? F_MIN : F_MAX);
      return w;
    end
    num = fm << (2 * INT_FRAC);
    q = num / den;
    if (q > (128'd1 << 62)) q = 128'd1 << 62;
    qneg = fneg != dneg;
    g = (fneg ? -$signed(fm) : $signed(fm)) + (qneg ? -$signed(q) : $signed(q));
    gneg = g < 0;
    gm = gneg ? 128'(-g) : 128'(g);
    dv = len << INT_FRAC;
    p = 128'(stiffness) * gm * dm[0];
    w.fx = clamp_q16(p / dv, gneg != dn[0]);
    p = 128'(stiffness) * gm * dm[1];
    w.fy = clamp_q16(p / dv, gneg != dn[1]);
    p = 128'(stiffness) * gm * dm[2];
    w.fz = clamp_q16(p / dv, gneg != dn[2]);
    return w;
  endfunction

  always @(posedge clk) begin
    force_word_t e;
    force_word_t got;
    if (rst) begin
      stiffness <= STIFF_RESET;
      rest_len  <= REST_RESET;
      abs_den   <= 1'b0;
      errors    <= 0;
      expected_forces.delete();
    end else begin
      if (start && !busy)
        expected_forces.push_back(link_force(first_present, second_present,
          '{first_x, first_y, first_z}, '{second_x, second_y, second_z}));
      if (done) begin
        got = '{pair_valid, degenerate, force_x, force_y, force_z};
        if (expected_forces.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result word %h", got);
        end else begin
          e = expected_forces.pop_front();
          if (got !== e) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: exp pv=%b dg=%b f=%h %h %h, got pv=%b dg=%b f=%h %h %h",
                e.pv, e.dg, e.fx, e.fy, e.fz, got.pv, got.dg, got.fx, got.fy, got.fz);
          end
        end
      end
      if (wr_en) begin
        case (wr_index)
          REG_STIFFNESS:   stiffness <= wr_data;
          REG_REST_LENGTH: rest_len  <= wr_data;
          REG_ABS_DEN:     abs_den   <= wr_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb;
  import clsf_pkg::*;

  localparam longint CYCLE_LIMIT = 3_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy, done;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = REG_STIFFNESS;
  logic [31:0] wr_data = '0;
  logic        first_present = 1'b0, second_present = 1'b0;
  logic [31:0] first_x = '0, first_y = '0, first_z = '0;
  logic [31:0] second_x = '0, second_y = '0, second_z = '0;
  logic        pair_valid, degenerate;
  logic [31:0] force_x, force_y, force_z;
  int          errors, pending;
  longint      cycles = 0;
  logic [31:0] rest_now = REST_RESET;
  bit          idling = 1'b1;

  always #5 clk = ~clk;

  chain_link_spring_force DUT (.*);
  clsf_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic put_word(logic fp, logic sp, logic [31:0] ax, logic [31:0] ay,
                          logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                          logic [31:0] bz);
    start <= 1'b1;
    first_present <= fp; second_present <= sp;
    first_x <= ax; first_y <= ay; first_z <= az;
    second_x <= bx; second_y <= by; second_z <= bz;
    do @(posedge clk); while (busy);
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic put_edge(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    logic [31:0] ax, ay, az;
    ax = $urandom; ay = $urandom; az = $urandom;
    if ($urandom_range(0, 1)) begin
      ax = 32'($signed(ax) >>> 2); ay = 32'($signed(ay) >>> 2);
      az = 32'($signed(az) >>> 2);
    end
    put_word(1'b1, 1'b1, ax, ay, az, ax + dx, ay + dy, az + dz);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [31:0] val);
    start <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 8) @(posedge clk);
    wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_REST_LENGTH) rest_now = val;
  endtask

  function automatic logic [31:0] comp(int sh);
    return 32'($signed($urandom) >>> sh);
  endfunction

  task automatic random_words(int n);
    logic [31:0] l;
    int sh;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: put_word(1'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        1: put_edge(0, 0, 0);
        2: begin
          l = rest_now << 2;
          if (rest_now < 32'h4000_0000)
            case ($urandom_range(0, 2))
              0: put_edge($urandom_range(0, 1) ? l : -l, 0, 0);
              1: put_edge(0, $urandom_range(0, 1) ? l : -l, 0);
              default: put_edge(0, 0, $urandom_range(0, 1) ? l : -l);
            endcase
          else put_edge(l, 0, 0);
        end
        3, 4: begin
          l = rest_now + comp($urandom_range(4, 31));
          put_edge(l, comp($urandom_range(10, 31)), comp($urandom_range(10, 31)));
        end
        default: begin
          sh = $urandom_range(0, 31);
          put_edge(comp(sh), comp(sh), comp(sh));
        end
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner words at reset settings
    put_word(1'b0, 1'b1, 1, 2, 3, 4, 5, 6);
    put_word(1'b1, 1'b0, 1, 2, 3, 4, 5, 6);
    put_word(1'b0, 1'b0, '1, '1, '1, 0, 0, 0);
    put_edge(0, 0, 0);
    put_word(1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    put_word(1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    put_edge(32'h0004_0000, 0, 0);
    put_edge(-32'sh0004_0000, 0, 0);
    put_edge(0, 32'h0004_0000, 0);
    put_edge(0, 0, -32'sh0004_0000);
    put_edge(32'h0001_0000, 0, 0);
    put_edge(32'h0000_8000, 32'h0000_8000, 0);
    put_edge(1, 0, 0);
    put_edge(32'h0005_0000, 0, 0);
    put_edge(32'h0010_0000, -32'sh0010_0000, 32'h0010_0000);
    random_words(200);

    set_reg(REG_ABS_DEN, 1);
    put_edge(32'h0005_0000, 0, 0);
    put_edge(-32'sh0004_0000, 0, 0);
    put_edge(32'h0100_0000, 32'h0001_0000, 0);
    random_words(200);

    set_reg(REG_STIFFNESS, '1);
    set_reg(REG_REST_LENGTH, 1);
    put_edge(4, 0, 0);
    put_edge(0, -4, 0);
    put_edge(1, 1, 1);
    random_words(220);

    set_reg(REG_STIFFNESS, 0);
    set_reg(REG_REST_LENGTH, '1);
    set_reg(REG_ABS_DEN, 0);
    random_words(200);

    set_reg(REG_STIFFNESS, $urandom);
    set_reg(REG_REST_LENGTH, $urandom_range(1, 32'h0100_0000));
    random_words(250);

    set_reg(REG_STIFFNESS, $urandom_range(1, 32'h0010_0000));
    set_reg(REG_REST_LENGTH, 0);
    set_reg(REG_ABS_DEN, 1);
    random_words(200);

    set_reg(REG_STIFFNESS, $urandom);
    set_reg(REG_REST_LENGTH, $urandom_range(1, 32'h0004_0000));
    set_reg(REG_ABS_DEN, 0);
    random_words(230);

    idling = 1'b0;
    set_reg(REG_REST_LENGTH, $urandom_range(1, 32'h0100_0000));
    random_words(230);

    start <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
